// ===== rtl/indexed_max_priority_point_map_core_macros.svh =====
// assertion macros used by the point map core
`ifndef INDEXED_MAX_PRIORITY_POINT_MAP_CORE_MACROS_SVH
`define INDEXED_MAX_PRIORITY_POINT_MAP_CORE_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define IMPPM_ASSERT_NOW(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("point map check failed");

// condition must hold in the cycle after the trigger
`define IMPPM_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("point map check failed");

`endif

// ===== rtl/imppm_pkg.sv =====
// types and constants shared by the point map rtl
package imppm_pkg;

  localparam int COORD_W   = 6;
  localparam int DELTA_W   = 16;
  localparam int COUNT_W   = 13;
  localparam int STAMP_W   = 32;

  localparam logic [COUNT_W-1:0] MAX_POINTS = 13'd4096;
  localparam logic [STAMP_W-1:0] STAMP_MAX  = '1;

  typedef enum logic [1:0] {
    KIND_SET    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_CLEAR  = 2'd3
  } imppm_kind_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic [DELTA_W-1:0] delta_value;
  } imppm_in_t;

  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] best_x;
    logic [COORD_W-1:0] best_y;
    logic [COUNT_W-1:0] point_count;
  } imppm_out_t;

  // control from the sequencer to the best-entry tracker
  typedef struct packed {
    logic start;
    logic sample;
  } imppm_scan_ctl_t;

endpackage

// ===== rtl/indexed_max_priority_point_map_core.sv =====
// top level of the indexed max-priority point map: sequencer, counters, result register
//
//   channel  dir  handshake                     word
//   item     in   item_valid / item_stall       imppm_in_t  (kind, point_x, point_y, delta_value)
//   result   out  result_valid / result_stall   imppm_out_t (found, best_x, best_y, point_count)
//
// one word at a time; item_stall is high from acceptance until the result is registered
// set / remove: after acceptance the engine reads the entry, writes it (in-grid points only), loads the result
// query: one memory read and one compare per cell
// clear: one memory write per cell
// after reset a clearing pass over every cell runs before the first word
// a stalled result holds the engine in its final step; the result register parts the sides

`include "indexed_max_priority_point_map_core_macros.svh"

module indexed_max_priority_point_map_core #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64,
  parameter int VALUE_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  imppm_pkg::imppm_in_t  item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output imppm_pkg::imppm_out_t result
);
  import imppm_pkg::*;

  localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int XW         = $clog2(GRID_WIDTH);
  localparam int YW         = $clog2(GRID_HEIGHT);
  // entry word: valid, value, stamp
  localparam int DW         = 1 + VALUE_BITS + STAMP_W;

  localparam logic [AW-1:0] LAST_ADDR = AW'(CELL_COUNT - 1);
  localparam logic [XW-1:0] LAST_X    = XW'(GRID_WIDTH - 1);

  typedef enum logic [2:0] {
    S_CLEAR,   // sweep every cell to invalid (after reset and for clear)
    S_IDLE,    // waiting for a word
    S_READ,    // read the addressed entry
    S_WRITE,   // update the entry and the counters
    S_SCAN,    // one cell read per cycle
    S_DRAIN,   // compare the last cell read
    S_DONE     // load the result register
  } state_t;

  state_t state;

  // latched item
  imppm_kind_t           item_kind;
  logic [COORD_W-1:0]    item_x;
  logic [COORD_W-1:0]    item_y;
  logic [VALUE_BITS-1:0] item_val;
  logic                  item_in_grid;

  logic [COUNT_W-1:0]    stored_count;
  logic [STAMP_W-1:0]    stamp_counter;
  logic                  clear_op;

  // scan and sweep position; tag is the cell whose read data arrives this cycle
  logic [AW-1:0]         scan_addr;
  logic [XW-1:0]         scan_x;
  logic [YW-1:0]         scan_y;
  logic [XW-1:0]         tag_x;
  logic [YW-1:0]         tag_y;
  logic                  sample_pending;

  // memory side
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DW-1:0]         wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [DW-1:0]         rd_data;
  logic                  old_valid;
  logic [VALUE_BITS-1:0] old_value;
  logic [STAMP_W-1:0]    old_stamp;

  logic [31:0]           idx_full;
  logic [AW-1:0]         item_idx;
  logic                  item_take;
  imppm_scan_ctl_t       scan_ctl;
  logic                  have;
  logic [XW-1:0]         best_x;
  logic [YW-1:0]         best_y;
  logic                  hit;

  assign item_stall = (state != S_IDLE);
  assign item_take  = item_valid && !item_stall;

  // row-major cell address of the latched point
  assign idx_full = 32'(item_y) * 32'(GRID_WIDTH) + 32'(item_x);
  assign item_idx = idx_full[AW-1:0];

  assign old_valid = rd_data[DW-1];
  assign old_value = rd_data[DW-2 -: VALUE_BITS];
  assign old_stamp = rd_data[STAMP_W-1:0];

  assign hit = (item_kind == KIND_QUERY) && have;

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = item_idx;
    wr_data  = '0;
    rd_en    = 1'b0;
    rd_addr  = item_idx;
    scan_ctl = '0;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = scan_addr;
      end
      S_IDLE: begin
        scan_ctl.start = item_take && (imppm_kind_t'(item.kind) == KIND_QUERY);
      end
      S_READ: begin
        rd_en = item_in_grid;
      end
      S_WRITE: begin
        // set stores a fresh entry; remove invalidates only a present one
        if (item_kind == KIND_SET) begin
          wr_en   = 1'b1;
          wr_data = {1'b1, item_val, stamp_counter};
        end else begin
          wr_en = old_valid;
        end
      end
      S_SCAN: begin
        rd_en           = 1'b1;
        rd_addr         = scan_addr;
        scan_ctl.sample = sample_pending;
      end
      S_DRAIN: begin
        scan_ctl.sample = sample_pending;
      end
      S_DONE: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clear_op       <= 1'b0;
      scan_addr      <= '0;
      stored_count   <= '0;
      stamp_counter  <= '0;
      sample_pending <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      // the final step reloads the result register itself
      if (result_valid && !result_stall && (state != S_DONE)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            item_kind    <= imppm_kind_t'(item.kind);
            item_x       <= item.point_x;
            item_y       <= item.point_y;
            item_val     <= VALUE_BITS'(item.delta_value);
            item_in_grid <= (32'(item.point_x) < 32'(GRID_WIDTH)) &&
                            (32'(item.point_y) < 32'(GRID_HEIGHT));
            unique case (imppm_kind_t'(item.kind))
              KIND_SET, KIND_REMOVE: begin
                state <= S_READ;
              end
              KIND_QUERY: begin
                scan_addr      <= '0;
                scan_x         <= '0;
                scan_y         <= '0;
                sample_pending <= 1'b0;
                state          <= S_SCAN;
              end
              KIND_CLEAR: begin
                scan_addr    <= '0;
                clear_op     <= 1'b1;
                stored_count <= '0;
                state        <= S_CLEAR;
              end
            endcase
          end
        end
        S_CLEAR: begin
          scan_addr <= scan_addr + AW'(1);
          if (scan_addr == LAST_ADDR) begin
            state <= clear_op ? S_DONE : S_IDLE;
          end
        end
        S_READ: begin
          state <= item_in_grid ? S_WRITE : S_DONE;
        end
        S_WRITE: begin
          if (item_kind == KIND_SET) begin
            if (!old_valid) begin
              stored_count <= stored_count + COUNT_W'(1);
            end
            if (stamp_counter != STAMP_MAX) begin
              stamp_counter <= stamp_counter + STAMP_W'(1);
            end
          end else if (old_valid) begin
            stored_count <= stored_count - COUNT_W'(1);
          end
          state <= S_DONE;
        end
        S_SCAN: begin
          sample_pending <= 1'b1;
          tag_x          <= scan_x;
          tag_y          <= scan_y;
          scan_addr      <= scan_addr + AW'(1);
          if (scan_x == LAST_X) begin
            scan_x <= '0;
            scan_y <= scan_y + YW'(1);
          end else begin
            scan_x <= scan_x + XW'(1);
          end
          if (scan_addr == LAST_ADDR) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          sample_pending <= 1'b0;
          state          <= S_DONE;
        end
        S_DONE: begin
          // wait for a free result register
          if (!result_valid || !result_stall) begin
            result.found       <= hit;
            result.best_x      <= hit ? COORD_W'(best_x) : '0;
            result.best_y      <= hit ? COORD_W'(best_y) : '0;
            result.point_count <= stored_count;
            result_valid       <= 1'b1;
            clear_op           <= 1'b0;
            state              <= S_IDLE;
          end
        end
      endcase
    end
  end

  imppm_table #(
    .DEPTH (CELL_COUNT),
    .AW    (AW),
    .DW    (DW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  imppm_best #(
    .VALUE_BITS (VALUE_BITS),
    .XW         (XW),
    .YW         (YW)
  ) u_best (
    .clk         (clk),
    .rst         (rst),
    .ctl         (scan_ctl),
    .entry_valid (old_valid),
    .entry_value (old_value),
    .entry_stamp (old_stamp),
    .entry_x     (tag_x),
    .entry_y     (tag_y),
    .have        (have),
    .best_x      (best_x),
    .best_y      (best_y)
  );

  // engine is still busy in the cycle after taking a word
  `IMPPM_ASSERT_NEXT(a_busy_after_take, item_valid && !item_stall, item_stall)
  // a query scan never modifies the table
  `IMPPM_ASSERT_NOW(a_no_write_in_scan, state == S_SCAN || state == S_DRAIN, !wr_en)
  // the count can never pass the number of addressable points
  `IMPPM_ASSERT_NOW(a_count_bound, 1'b1, stored_count <= MAX_POINTS)
  // a saturated stamp stays saturated
  `IMPPM_ASSERT_NEXT(a_stamp_sticks, stamp_counter == STAMP_MAX, stamp_counter == STAMP_MAX)
  // results without a hit carry a zero point
  `IMPPM_ASSERT_NOW(a_empty_point, result_valid && !result.found, result.best_x == '0 && result.best_y == '0)

endmodule

// ===== rtl/imppm_table.sv =====
// entry memory: one write port, one registered read port
module imppm_table #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 49
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/imppm_best.sv =====
// running best-entry tracker: shared value/stamp compare used once per scanned entry
module imppm_best #(
  parameter int VALUE_BITS = 16,
  parameter int XW         = 6,
  parameter int YW         = 6
) (
  input  logic                    clk,
  input  logic                    rst,
  input  imppm_pkg::imppm_scan_ctl_t ctl,
  input  logic                    entry_valid,
  input  logic [VALUE_BITS-1:0]   entry_value,
  input  logic [imppm_pkg::STAMP_W-1:0] entry_stamp,
  input  logic [XW-1:0]           entry_x,
  input  logic [YW-1:0]           entry_y,
  output logic                    have,
  output logic [XW-1:0]           best_x,
  output logic [YW-1:0]           best_y
);
  import imppm_pkg::*;

  logic [VALUE_BITS-1:0] best_value;
  logic [STAMP_W-1:0]    best_stamp;
  logic                  better;

  // higher value wins, newer stamp breaks a tie, full tie keeps the earlier entry
  always_comb begin
    better = !have || (entry_value > best_value) ||
             ((entry_value == best_value) && (entry_stamp > best_stamp));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (ctl.start) begin
      have <= 1'b0;
    end else if (ctl.sample && entry_valid && better) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ctl.start && ctl.sample && entry_valid && better) begin
      best_value <= entry_value;
      best_stamp <= entry_stamp;
      best_x     <= entry_x;
      best_y     <= entry_y;
    end
  end

endmodule
